FILE: src/leir_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line edit input ring.
package leir_pkg;

   localparam int CHAR_W  = 8;
   localparam int LIMIT_W = 7;
   localparam int KIND_W  = 2;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'd10;

   localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NOLINE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd3;

   typedef struct packed {
      logic               cmd;
      logic [CHAR_W-1:0]  char_in;
      logic [LIMIT_W-1:0] read_limit;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] data_out;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ
   } seq_state_type;

endpackage

FILE: src/leir_store.sv
`timescale 1ns / 1ps
// Character ring storage: one write port, one registered read port.
module leir_store
   import leir_pkg::*;
#(
   parameter int RING_DEPTH = 64,
   localparam int PosW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [PosW-1:0]   wr_addr,
   input  logic [CHAR_W-1:0] wr_data,
   input  logic [PosW-1:0]   rd_addr,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem [RING_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/leir_seq.sv
`timescale 1ns / 1ps
// Sequencer: decodes a word, updates ring pointers and counters, drains reads.
module leir_seq
   import leir_pkg::*;
#(
   parameter int RING_DEPTH = 64,
   localparam int PosW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
   localparam int CntW = $clog2(RING_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_word,
   input  logic              slot_free,
   output logic              emit,
   output rsp_type           emit_word,
   output logic              wr_en,
   output logic [PosW-1:0]   wr_addr,
   output logic [CHAR_W-1:0] wr_data,
   output logic [PosW-1:0]   rd_addr,
   input  logic [CHAR_W-1:0] rd_data
);

   localparam logic [CntW-1:0] DEPTH_C = CntW'(RING_DEPTH);
   localparam logic [PosW-1:0] LAST_POS = PosW'(RING_DEPTH - 1);

   seq_state_type      state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LIMIT_W-1:0] cnt_ff, cnt_in;
   logic [PosW-1:0]    wpos_ff, wpos_in;
   logic [PosW-1:0]    rpos_ff, rpos_in;
   logic [CntW-1:0]    fill_ff, fill_in;
   logic [CntW-1:0]    open_ff, open_in;
   logic [CntW-1:0]    nl_ff, nl_in;

   logic [PosW-1:0] wpos_inc, wpos_dec, rpos_inc;
   logic            rd_last;

   assign wpos_inc = (wpos_ff == LAST_POS) ? '0 : wpos_ff + PosW'(1);
   assign wpos_dec = (wpos_ff == '0) ? LAST_POS : wpos_ff - PosW'(1);
   assign rpos_inc = (rpos_ff == LAST_POS) ? '0 : rpos_ff + PosW'(1);

   assign rd_last = (cnt_ff + LIMIT_W'(1) == limit_ff) || (fill_ff == CntW'(1))
                    || (rd_data == KEY_NEWLINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wpos_ff  <= '0;
         rpos_ff  <= '0;
         fill_ff  <= '0;
         open_ff  <= '0;
         nl_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wpos_ff  <= wpos_in;
         rpos_ff  <= rpos_in;
         fill_ff  <= fill_in;
         open_ff  <= open_in;
         nl_ff    <= nl_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      char_ff  <= char_in;
      limit_ff <= limit_in;
      cnt_ff   <= cnt_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      char_in   = char_ff;
      limit_in  = limit_ff;
      cnt_in    = cnt_ff;
      wpos_in   = wpos_ff;
      rpos_in   = rpos_ff;
      fill_in   = fill_ff;
      open_in   = open_ff;
      nl_in     = nl_ff;
      req_ready = 1'b0;
      emit      = 1'b0;
      emit_word = '0;
      wr_en     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_word.cmd;
               char_in  = req_word.char_in;
               limit_in = req_word.read_limit;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (cmd_ff == CMD_PUSH) begin
               if (char_ff == KEY_BACKSPACE) begin
                  if (open_ff == '0) begin
                     state_in = ST_IDLE;
                  end else if (slot_free) begin
                     emit      = 1'b1;
                     emit_word = '{kind: KIND_ECHO, data_out: KEY_BACKSPACE, last: 1'b1};
                     if (fill_ff != '0) begin
                        wpos_in = wpos_dec;
                        fill_in = fill_ff - CntW'(1);
                        open_in = open_ff - CntW'(1);
                     end
                     state_in = ST_IDLE;
                  end
               end else if (fill_ff >= DEPTH_C) begin
                  state_in = ST_IDLE;
               end else if (slot_free) begin
                  wr_en     = 1'b1;
                  wpos_in   = wpos_inc;
                  fill_in   = fill_ff + CntW'(1);
                  if (char_ff == KEY_NEWLINE) begin
                     open_in = '0;
                     nl_in   = nl_ff + CntW'(1);
                  end else begin
                     open_in = open_ff + CntW'(1);
                  end
                  emit      = 1'b1;
                  emit_word = '{kind: KIND_ECHO, data_out: char_ff, last: 1'b1};
                  state_in  = ST_IDLE;
               end
            end else begin
               if (nl_ff == '0) begin
                  if (slot_free) begin
                     emit      = 1'b1;
                     emit_word = '{kind: KIND_NOLINE, data_out: '0, last: 1'b1};
                     state_in  = ST_IDLE;
                  end
               end else if (limit_ff == '0) begin
                  if (slot_free) begin
                     emit      = 1'b1;
                     emit_word = '{kind: KIND_EMPTY, data_out: '0, last: 1'b1};
                     state_in  = ST_IDLE;
                  end
               end else begin
                  cnt_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_word = '{kind: KIND_READ, data_out: rd_data, last: rd_last};
               rpos_in   = rpos_inc;
               fill_in   = fill_ff - CntW'(1);
               cnt_in    = cnt_ff + LIMIT_W'(1);
               if ((rd_data == KEY_NEWLINE) && (nl_ff != '0)) begin
                  nl_in = nl_ff - CntW'(1);
               end
               if (rd_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read port looks one word ahead so the ring drains one byte per cycle while the output slot is free
   assign rd_addr = rpos_in;
   assign wr_addr = wpos_ff;
   assign wr_data = char_ff;

`ifndef NO_ASSERTIONS
   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("result issued while output register busy");

   a_counts_fit: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, open_ff} + {1'b0, nl_ff}) <= {1'b0, fill_ff})
      else $error("line and newline counts exceed stored bytes");

   a_last_ends_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && emit && emit_word.last) |=> state_ff == ST_IDLE)
      else $error("read continued after its last byte");

   a_store_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !wr_en)
      else $error("ring written during a read drain");
`endif

endmodule

FILE: src/line_edit_input_ring_unit.sv
`timescale 1ns / 1ps
// An echo, no-line or zero-limit result passes decode, then the output register, once its word is accepted;
// the first byte of a read passes decode, then the ring read, then the output register.
// Push: each word is accepted, then decoded with an update of the ring pointers before the next is taken.
// Read: the bytes drain in order after decode; while the output register is held off, the drain stalls.
// Reset is synchronous: pointers, fill/line/newline counters and output valid clear; ring data is not cleared.
// Line edit input ring: top level with the result output register.
module line_edit_input_ring_unit
   import leir_pkg::*;
#(
   parameter int RING_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int PosW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   logic              slot_free;
   logic              emit;
   rsp_type           emit_word;
   logic              wr_en;
   logic [PosW-1:0]   wr_addr;
   logic [CHAR_W-1:0] wr_data;
   logic [PosW-1:0]   rd_addr;
   logic [CHAR_W-1:0] rd_data;

   logic    rsp_valid_ff;
   rsp_type rsp_word_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   leir_seq #(
      .RING_DEPTH (RING_DEPTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .slot_free (slot_free),
      .emit      (emit),
      .emit_word (emit_word),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   leir_store #(
      .RING_DEPTH (RING_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= emit_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
